// File: design/sgd_pkg.sv
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared types, sizes and codes for the sobel gradient / direction block.
// ----------------------------------------------------------------------------
package sgd_pkg;

  // frame size limits
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;

  // derived widths
  localparam int ColW    = $clog2(MaxWidth);
  localparam int WDimW   = $clog2(MaxWidth + 1);
  localparam int HDimW   = $clog2(MaxHeight + 1);
  localparam int RowW    = $clog2(MaxHeight + 2);
  localparam int CfgW    = 11;
  localparam int CfgIdxW = 2;

  // queue between front and back
  localparam int QDepth = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 2'd1;

  // direction codes
  localparam logic [2:0] DIR_FLAT    = 3'd1;
  localparam logic [2:0] DIR_RISING  = 3'd2;
  localparam logic [2:0] DIR_FALLING = 3'd3;
  localparam logic [2:0] DIR_STEEP   = 3'd4;

  // request item
  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel;
  } req_t;

  // result item
  typedef struct packed {
    logic [7:0] magnitude;
    logic [2:0] direction;
    logic       last_in_frame;
  } res_t;

  // gradient pair handed from front to back
  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic               last;
  } grad_t;

endpackage

// File: design/sgd_ram.sv
// ----------------------------------------------------------------------------
// sgd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // read before write on the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sgd_queue.sv
// ----------------------------------------------------------------------------
// sgd_queue
// Small flip-flop fifo carrying gradient pairs from front to back.
// ----------------------------------------------------------------------------
module sgd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sgd_pkg::grad_t push_data,
  input  logic          pop,
  output sgd_pkg::grad_t pop_data,
  output logic          full,
  output logic          empty
);

  localparam int PtrW = $clog2(sgd_pkg::QDepth);

  sgd_pkg::grad_t            store [sgd_pkg::QDepth];
  logic [PtrW-1:0]           wr_ptr;
  logic [PtrW-1:0]           rd_ptr;
  logic [$clog2(sgd_pkg::QDepth+1)-1:0] count;

  assign full     = (count == ($clog2(sgd_pkg::QDepth+1))'(sgd_pkg::QDepth));
  assign empty    = (count == '0);
  assign pop_data = store[rd_ptr];

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/sgd_front.sv
// ----------------------------------------------------------------------------
// sgd_front
// Takes requests, keeps two line buffers and the window columns, tracks
// frame position and forms gx / gy for every result position.
// ----------------------------------------------------------------------------
module sgd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sgd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [sgd_pkg::CfgW-1:0]       cfg_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  sgd_pkg::req_t                  req,
  output logic                           q_push,
  output sgd_pkg::grad_t                 q_data,
  input  logic                           q_full
);

  typedef enum logic {F_IDLE, F_READ} fstate_t;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } col_t;

  fstate_t                       state;
  logic [7:0]                    val;
  logic [sgd_pkg::WDimW-1:0]     width;
  logic [sgd_pkg::HDimW-1:0]     height;
  logic [sgd_pkg::ColW-1:0]      in_col;
  logic [sgd_pkg::RowW-1:0]      in_row;
  logic [sgd_pkg::ColW-1:0]      out_col;
  logic [sgd_pkg::RowW-1:0]      out_row;
  col_t                          left_col;
  col_t                          cen_col;
  col_t                          new_col;
  logic [7:0]                    a_rd;
  logic [7:0]                    b_rd;
  logic                          accept;
  logic                          emit;
  logic                          last;
  logic [sgd_pkg::WDimW-1:0]     w_m1;
  logic [sgd_pkg::ColW-1:0]      col_end;
  logic [sgd_pkg::RowW-1:0]      row_end;
  logic                          top_ok, bot_ok, left_ok, right_ok;
  logic [7:0]                    tl, tc, tr, ml, mr, bl, bc, br;
  logic [9:0]                    xl, xr, yt, yb;

  // clamp a register value into 1..max
  function automatic logic [sgd_pkg::WDimW-1:0] clamp_w(logic [sgd_pkg::CfgW-1:0] v);
    if (v == '0) return sgd_pkg::WDimW'(1);
    if (int'(v) > sgd_pkg::MaxWidth) return sgd_pkg::WDimW'(sgd_pkg::MaxWidth);
    return sgd_pkg::WDimW'(v);
  endfunction

  function automatic logic [sgd_pkg::HDimW-1:0] clamp_h(logic [sgd_pkg::CfgW-1:0] v);
    if (v == '0) return sgd_pkg::HDimW'(1);
    if (int'(v) > sgd_pkg::MaxHeight) return sgd_pkg::HDimW'(sgd_pkg::MaxHeight);
    return sgd_pkg::HDimW'(v);
  endfunction

  assign req_stall = (state != F_IDLE) || q_full;
  assign accept    = req_valid && !req_stall;

  // line buffers: upper holds row-2, middle holds row-1 at each column
  sgd_ram #(.Width(8), .Depth(sgd_pkg::MaxWidth)) u_middle (
    .clk   (clk),
    .we    (state == F_READ),
    .waddr (in_col),
    .wdata (val),
    .raddr (in_col),
    .rdata (a_rd)
  );

  sgd_ram #(.Width(8), .Depth(sgd_pkg::MaxWidth)) u_upper (
    .clk   (clk),
    .we    (state == F_READ),
    .waddr (in_col),
    .wdata (a_rd),
    .raddr (in_col),
    .rdata (b_rd)
  );

  // position decode
  always_comb begin
    w_m1     = width - sgd_pkg::WDimW'(1);
    col_end  = w_m1[sgd_pkg::ColW-1:0];
    row_end  = sgd_pkg::RowW'(height) - sgd_pkg::RowW'(1);
    emit     = (in_row >= sgd_pkg::RowW'(2)) ||
               ((in_row == sgd_pkg::RowW'(1)) && (in_col != '0));
    last     = emit && (out_row == row_end) && (out_col == col_end);
    top_ok   = (out_row != '0);
    bot_ok   = (out_row != row_end);
    left_ok  = (out_col != '0);
    right_ok = (out_col != col_end);
  end

  // window taps with frame edges forced to zero
  always_comb begin
    new_col = '{top: b_rd, mid: a_rd, bot: val};
    tl = (top_ok && left_ok)  ? left_col.top : 8'd0;
    tc = top_ok               ? cen_col.top  : 8'd0;
    tr = (top_ok && right_ok) ? new_col.top  : 8'd0;
    ml = left_ok              ? left_col.mid : 8'd0;
    mr = right_ok             ? new_col.mid  : 8'd0;
    bl = (bot_ok && left_ok)  ? left_col.bot : 8'd0;
    bc = bot_ok               ? cen_col.bot  : 8'd0;
    br = (bot_ok && right_ok) ? new_col.bot  : 8'd0;
    xl = 10'(tl) + {1'b0, ml, 1'b0} + 10'(bl);
    xr = 10'(tr) + {1'b0, mr, 1'b0} + 10'(br);
    yt = 10'(tl) + {1'b0, tc, 1'b0} + 10'(tr);
    yb = 10'(bl) + {1'b0, bc, 1'b0} + 10'(br);
    q_data.gx   = $signed({1'b0, xr}) - $signed({1'b0, xl});
    q_data.gy   = $signed({1'b0, yb}) - $signed({1'b0, yt});
    q_data.last = last;
    q_push      = (state == F_READ) && emit;
  end

  // pixel latch and window shift
  always_ff @(posedge clk) begin
    if (accept) begin
      val <= req.req_type ? 8'd0 : req.pixel;
    end
    if (state == F_READ) begin
      left_col <= cen_col;
      cen_col  <= new_col;
    end
  end

  // control, counters and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      width   <= sgd_pkg::WDimW'(512);
      height  <= sgd_pkg::HDimW'(512);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cfg_we) begin
      if (cfg_index == sgd_pkg::REG_FRAME_WIDTH) begin
        width <= clamp_w(cfg_data);
      end else if (cfg_index == sgd_pkg::REG_FRAME_HEIGHT) begin
        height <= clamp_h(cfg_data);
      end
      if ((cfg_index == sgd_pkg::REG_FRAME_WIDTH) ||
          (cfg_index == sgd_pkg::REG_FRAME_HEIGHT)) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_READ;
          end
        end
        F_READ: begin
          state <= F_IDLE;
          if (last) begin
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
          end else begin
            if (emit) begin
              if (out_col == col_end) begin
                out_col <= '0;
                out_row <= out_row + sgd_pkg::RowW'(1);
              end else begin
                out_col <= out_col + sgd_pkg::ColW'(1);
              end
            end
            if (in_col == col_end) begin
              in_col <= '0;
              in_row <= in_row + sgd_pkg::RowW'(1);
            end else begin
              in_col <= in_col + sgd_pkg::ColW'(1);
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: design/sgd_back.sv
// ----------------------------------------------------------------------------
// sgd_back
// Turns a gradient pair into magnitude and direction: squares and ratio
// products, an iterative square root, rounding and the output register.
// ----------------------------------------------------------------------------
module sgd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  sgd_pkg::grad_t q_data,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_stall,
  output sgd_pkg::res_t  res
);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_ROOT, B_DONE} bstate_t;

  typedef struct packed {
    logic [10:0] rem;
    logic [9:0]  root;
  } root_t;

  localparam logic [30:0] TanLoQ32 = 31'd1779033704;
  localparam logic [33:0] TanHiQ32 = 34'd10368968294;

  bstate_t     state;
  logic [9:0]  ax, ay;
  logic        gx_pos, gy_pos, last;
  logic [19:0] sum_sq;
  logic [2:0]  dir;
  logic [2:0]  iter;
  root_t       cur;
  root_t       step1, step2;
  logic [19:0] ax_sq, ay_sq;
  logic [43:0] num, lo_p, hi_p;
  logic [2:0]  dir_next;
  logic [10:0] mag_round;
  logic [7:0]  mag_sat;
  logic        load_out;

  // one digit of the restoring square root
  function automatic root_t sqrt_step(root_t c, logic [1:0] pair);
    logic [12:0] rem_sh;
    logic [12:0] trial;
    root_t       n;
    rem_sh = {c.rem, pair};
    trial  = {1'b0, c.root, 2'b01};
    if (rem_sh >= trial) begin
      n.rem  = 11'(rem_sh - trial);
      n.root = {c.root[8:0], 1'b1};
    end else begin
      n.rem  = rem_sh[10:0];
      n.root = {c.root[8:0], 1'b0};
    end
    return n;
  endfunction

  assign q_pop = (state == B_IDLE) && !q_empty;

  // squares and tangent compares
  always_comb begin
    ax_sq = ax * ax;
    ay_sq = ay * ay;
    num   = {2'b00, ay, 32'd0};
    lo_p  = 44'(TanLoQ32) * 44'(ax);
    hi_p  = TanHiQ32 * 44'(ax);
    if (ax == '0) begin
      dir_next = sgd_pkg::DIR_STEEP;
    end else if (num < lo_p) begin
      dir_next = sgd_pkg::DIR_FLAT;
    end else if (num > hi_p) begin
      dir_next = sgd_pkg::DIR_STEEP;
    end else if (gx_pos == gy_pos) begin
      dir_next = sgd_pkg::DIR_RISING;
    end else begin
      dir_next = sgd_pkg::DIR_FALLING;
    end
  end

  // two root digits per cycle
  always_comb begin
    step1 = sqrt_step(cur, sum_sq[19:18]);
    step2 = sqrt_step(step1, sum_sq[17:16]);
  end

  // round to nearest and saturate
  always_comb begin
    mag_round = {1'b0, cur.root} + 11'(cur.rem > {1'b0, cur.root});
    mag_sat   = (mag_round > 11'd255) ? 8'd255 : mag_round[7:0];
    load_out  = (state == B_DONE) && (!res_valid || !res_stall);
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
      iter      <= '0;
    end else begin
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          state <= B_ROOT;
          iter  <= 3'd4;
        end
        B_ROOT: begin
          if (iter == '0) begin
            state <= B_DONE;
          end else begin
            iter <= iter - 3'd1;
          end
        end
        B_DONE: begin
          if (load_out) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ax     <= q_data.gx[10] ? 10'(-q_data.gx) : q_data.gx[9:0];
      ay     <= q_data.gy[10] ? 10'(-q_data.gy) : q_data.gy[9:0];
      gx_pos <= !q_data.gx[10] && (q_data.gx != '0);
      gy_pos <= !q_data.gy[10] && (q_data.gy != '0);
      last   <= q_data.last;
    end
    if (state == B_MUL) begin
      sum_sq <= {2'b00, ax_sq[19:2]} + {2'b00, ay_sq[19:2]};
      dir    <= dir_next;
      cur    <= '0;
    end
    if (state == B_ROOT) begin
      cur    <= step2;
      sum_sq <= {sum_sq[15:0], 4'd0};
    end
    if (load_out) begin
      res.magnitude     <= mag_sat;
      res.direction     <= dir;
      res.last_in_frame <= last;
    end
  end

endmodule

// File: design/sobel_gradient_direction_top.sv
// ----------------------------------------------------------------------------
// sobel_gradient_direction_top
// Sobel 3x3 gradient magnitude and direction over a raster pixel stream.
// ----------------------------------------------------------------------------
//   channel   signals                         role
//   request   req_valid / req_stall / req      pixel or drain in
//   result    res_valid / res_stall / res      magnitude, direction out
//   config    cfg_we / cfg_index / cfg_data    frame width and height
//
// The front takes no new request while the queue is full or while it reads,
// then writes, the line buffers. The back, which sets the sustained rate, takes
// a pair only when idle: squares, root at two digits per step, output register.
// A 4-entry queue between front and back lets either side stall alone.
// Reset is synchronous; line buffers are not cleared, edge taps are masked.
// ----------------------------------------------------------------------------
module sobel_gradient_direction_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sgd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sgd_pkg::CfgW-1:0]    cfg_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  sgd_pkg::req_t               req,
  output logic                        res_valid,
  input  logic                        res_stall,
  output sgd_pkg::res_t               res
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  sgd_pkg::grad_t q_in;
  sgd_pkg::grad_t q_out;

  // request side: position tracking and window
  sgd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  // decoupling queue
  sgd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // result side: magnitude and direction
  sgd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef SYNTHESIS
  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue overflow");

  // a taken request blocks the next cycle while the line buffers are written
  a_one_per_two: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall) else $error("request taken back to back");

  // results carry a legal direction code
  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.direction == sgd_pkg::DIR_FLAT ||
                   res.direction == sgd_pkg::DIR_RISING ||
                   res.direction == sgd_pkg::DIR_FALLING ||
                   res.direction == sgd_pkg::DIR_STEEP))
    else $error("bad direction code");
`endif

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sobel gradient / direction block: a software
// copy of the row store predicts magnitude, direction and frame end for each
// request; a checker process compares every result with the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [sgd_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [sgd_pkg::CfgW-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  sgd_pkg::req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  sgd_pkg::res_t res;

  sobel_gradient_direction_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0] pix_rows [4][sgd_pkg::MaxWidth];
  int unsigned width_reg, height_reg;
  int unsigned col_in, row_in, col_out, row_out;
  sgd_pkg::res_t pending_results [$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit hold_long = 1'b0;

  localparam longint unsigned TanLoQ32 = 64'd1779033704;
  localparam longint unsigned TanHiQ32 = 64'd10368968294;
  localparam int IdleLimit = 20000;

  // indexes with no register behind them
  localparam logic [sgd_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [sgd_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 1) return 1;
    if (v > sgd_pkg::MaxWidth) return sgd_pkg::MaxWidth;
    return v;
  endfunction

  function automatic int pixel_at(int r, int c, int w, int h);
    if (r < 0 || r >= h || c < 0 || c >= w) return 0;
    return pix_rows[r & 3][c];
  endfunction

  // predict the result (if any) caused by one request
  task automatic predict_gradient(sgd_pkg::req_t item);
    int w, h, r, c, gx, gy;
    longint unsigned ax, ay, s, mag, num;
    logic [2:0] dir;
    sgd_pkg::res_t exp_res;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (row_in < h) pix_rows[row_in & 3][col_in] = item.req_type ? 8'd0 : item.pixel;
    if (row_in * w + col_in >= w + 1) begin
      r = row_out;
      c = col_out;
      gx = (pixel_at(r-1, c+1, w, h) + 2*pixel_at(r, c+1, w, h) + pixel_at(r+1, c+1, w, h))
         - (pixel_at(r-1, c-1, w, h) + 2*pixel_at(r, c-1, w, h) + pixel_at(r+1, c-1, w, h));
      gy = (pixel_at(r+1, c-1, w, h) + 2*pixel_at(r+1, c, w, h) + pixel_at(r+1, c+1, w, h))
         - (pixel_at(r-1, c-1, w, h) + 2*pixel_at(r-1, c, w, h) + pixel_at(r-1, c+1, w, h));
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      s = (ax*ax)/4 + (ay*ay)/4;
      mag = 0;
      while ((mag+1)*(mag+1) <= s) mag++;
      if (s > mag*(mag+1)) mag++;
      if (mag > 255) mag = 255;
      num = ay << 32;
      if (ax == 0) dir = sgd_pkg::DIR_STEEP;
      else if (num < TanLoQ32*ax) dir = sgd_pkg::DIR_FLAT;
      else if (num > TanHiQ32*ax) dir = sgd_pkg::DIR_STEEP;
      else if ((gx > 0) == (gy > 0)) dir = sgd_pkg::DIR_RISING;
      else dir = sgd_pkg::DIR_FALLING;
      exp_res.magnitude = mag[7:0];
      exp_res.direction = dir;
      exp_res.last_in_frame = (row_out == h-1) && (col_out == w-1);
      pending_results = {pending_results, exp_res};
      if (exp_res.last_in_frame) begin
        col_in = 0; row_in = 0; col_out = 0; row_out = 0;
        return;
      end
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
  endtask

  // send one request after a random gap
  task automatic send_request(bit drain, logic [7:0] value, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    // valid drops only when a gap follows
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{req_type: drain, pixel: value};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_gradient('{req_type: drain, pixel: value});
  endtask

  task automatic wait_results_done();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_reg(logic [sgd_pkg::CfgIdxW-1:0] idx, int unsigned value);
    wait_results_done();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[sgd_pkg::CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sgd_pkg::REG_FRAME_WIDTH) begin
      width_reg = value & 11'h7FF;
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    end else if (idx == sgd_pkg::REG_FRAME_HEIGHT) begin
      height_reg = value & 11'h7FF;
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    end
  endtask

  // one full frame plus drain
  task automatic run_frame(int mode);
    int w, h;
    logic [7:0] v;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    for (int i = 0; i < w*h; i++) begin
      case (mode)
        0: v = 8'($urandom_range(0, 255));
        1: v = (i % 2) ? 8'hFF : 8'h00;
        2: v = ((i / w) % 2) ? 8'hFF : 8'h00;
        default: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      send_request(($urandom_range(0, 19) == 0), v);
    end
    for (int i = 0; i <= w; i++) send_request(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    write_reg(sgd_pkg::REG_FRAME_WIDTH, 3);
    write_reg(sgd_pkg::REG_FRAME_HEIGHT, 3);
    for (int i = 0; i < 9; i++) send_request(1'b0, (i % 3 == 2) ? 8'hFF : 8'h00);
    // pixel during the flush acts as drain
    send_request(1'b0, 8'hAA);
    for (int i = 0; i < 3; i++) send_request(1'b1, 8'h55);
    write_reg(sgd_pkg::REG_FRAME_WIDTH, 0);
    write_reg(sgd_pkg::REG_FRAME_HEIGHT, 0);
    send_request(1'b0, 8'hFF);
    send_request(1'b1, 8'h00);
    send_request(1'b1, 8'h00);
    // out of range clamps to max, then an abandoned partial frame
    write_reg(sgd_pkg::REG_FRAME_HEIGHT, 11'h7FF);
    write_reg(sgd_pkg::REG_FRAME_WIDTH, 11'h7FF);
    for (int i = 0; i < 5; i++) send_request(1'b0, 8'hFF);
    write_reg(RegSpareA, 5);
    write_reg(RegSpareB, 5);
  endtask

  task automatic test_random_frames();
    int n;
    n = 0;
    while (n < 600) begin
      write_reg(sgd_pkg::REG_FRAME_WIDTH, $urandom_range(1, 12));
      write_reg(sgd_pkg::REG_FRAME_HEIGHT, $urandom_range(1, 10));
      n += clamp_dim(width_reg) * (clamp_dim(height_reg) + 1) + 1;
      run_frame($urandom_range(0, 3));
    end
  endtask

  task automatic test_wide_frame();
    write_reg(sgd_pkg::REG_FRAME_WIDTH, 512);
    write_reg(sgd_pkg::REG_FRAME_HEIGHT, 1);
    run_frame(0);
    write_reg(sgd_pkg::REG_FRAME_WIDTH, 2);
    write_reg(sgd_pkg::REG_FRAME_HEIGHT, 100);
    run_frame(3);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    write_reg(sgd_pkg::REG_FRAME_WIDTH, 6);
    write_reg(sgd_pkg::REG_FRAME_HEIGHT, 6);
    hold_long = 1'b1;
    for (int i = 0; i < 36; i++) send_request(1'b0, 8'($urandom_range(0, 255)), 1);
    for (int i = 0; i < 7; i++) send_request(1'b1, 8'h00, 1);
    wait_results_done();
  endtask

  // receiver stall
  always @(posedge clk) begin
    static int wait_left = 0;
    static int long_left = 0;
    if (hold_long) begin
      hold_long = 1'b0;
      long_left = 200;
    end
    if (long_left > 0) begin
      long_left--;
      res_stall <= 1'b1;
    end else if (res_valid && !res_stall) begin
      wait_left = $urandom_range(0, 4);
      res_stall <= (wait_left != 0);
    end else if (wait_left > 0) begin
      wait_left--;
      res_stall <= (wait_left != 0);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    sgd_pkg::res_t exp_res;
    if (!rst) begin
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", res);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res.magnitude !== exp_res.magnitude) begin
          $error("magnitude expected %0d actual %0d", exp_res.magnitude, res.magnitude);
          fail_count++;
        end
        if (res.direction !== exp_res.direction) begin
          $error("direction expected %0d actual %0d", exp_res.direction, res.direction);
          fail_count++;
        end
        if (res.last_in_frame !== exp_res.last_in_frame) begin
          $error("last_in_frame expected %0d actual %0d", exp_res.last_in_frame,
                 res.last_in_frame);
          fail_count++;
        end
      end
    end
  end

  initial begin
    width_reg = 512;
    height_reg = 512;
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    foreach (pix_rows[i, j]) pix_rows[i][j] = 8'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_frames();
    test_wide_frame();
    wait_results_done();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
